>>> rtl/wctd_pkg.sv
// Shared types, constants and helper functions for the window copy token decompressor.
package wctd_pkg;

   localparam int HISTORY_DEPTH_DEF = 4096;
   localparam int MAX_RUN_DEF       = 63;

   localparam int BYTE_W  = 8;
   localparam int DIGIT_W = 6;
   localparam int RUN_W   = 6;   // holds any run length up to the cap
   localparam int OFF_W   = 12;  // two 6-bit digits
   localparam int LEN_W   = 13;  // two 6-bit digits plus one
   localparam int CNT_W   = 24;  // four 6-bit digits
   localparam int QDIG_W  = 5;   // base-19 quick digit
   localparam int QPAIR_W = 9;   // two quick digits
   localparam int Q_DEPTH = 2;

   localparam logic [BYTE_W-1:0]  BYTE_ALT_ZERO = 8'hFF;
   localparam logic [BYTE_W-1:0]  INSTR_LO      = 8'd34;
   localparam logic [BYTE_W-1:0]  INSTR_HI      = 8'd41;
   localparam logic [BYTE_W-1:0]  QUICK_LO      = 8'd42;
   localparam logic [BYTE_W-1:0]  QUICK_HI      = 8'd60;
   localparam logic [BYTE_W-1:0]  COPY_LO       = 8'd63;
   localparam logic [BYTE_W-1:0]  COPY_HI       = 8'd126;
   localparam logic [QPAIR_W-1:0] QUICK_BASE    = 9'd19;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_OFF_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_CNT_FIRST,
      PH_CNT_QUICK,
      PH_CNT_D1,
      PH_CNT_D2,
      PH_CNT_D3,
      PH_NAKED_QUICK
   } phase_type;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_COPY,
      RUN_DUPE
   } run_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COPY,
      BK_DUPE,
      BK_CHAR
   } back_state_type;

   // one entry per request that gives any result
   typedef struct packed {
      run_type           kind;
      logic [RUN_W-1:0]  run_n;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic              cut;
      logic              has_char;
      logic [BYTE_W-1:0] chr;
   } cmd_type;

   function automatic logic [BYTE_W-1:0] instr_char(input logic [2:0] sel);
      logic [BYTE_W-1:0] ch;
      unique case (sel)
         3'd0: ch = 8'h3E;  // >
         3'd1: ch = 8'h3C;  // <
         3'd2: ch = 8'h2B;  // +
         3'd3: ch = 8'h2D;  // -
         3'd4: ch = 8'h2E;  // .
         3'd5: ch = 8'h2C;  // ,
         3'd6: ch = 8'h5B;  // [
         3'd7: ch = 8'h5D;  // ]
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/wctd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module wctd_ram #(
   parameter int WIDTH = wctd_pkg::BYTE_W,
   parameter int DEPTH = wctd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/wctd_front.sv
// Token parser: accepts one request per cycle unless q_full; emits run/char commands.
module wctd_front #(
   parameter int MAX_RUN = wctd_pkg::MAX_RUN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wctd_pkg::BYTE_W-1:0]     req_tdata,
   input  logic                            q_full,
   output logic                            push,
   output wctd_pkg::cmd_type               cmd
);

   localparam int PROD_W = 2 * wctd_pkg::RUN_W;

   wctd_pkg::phase_type                phase_ff, phase_in;
   logic [wctd_pkg::OFF_W-1:0]         offset_ff, offset_in;
   logic [wctd_pkg::LEN_W-1:0]         length_ff, length_in;
   logic [wctd_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [wctd_pkg::QDIG_W-1:0]        qlow_ff, qlow_in;

   logic                               accept;
   logic [wctd_pkg::BYTE_W-1:0]        b;
   logic [wctd_pkg::DIGIT_W-1:0]       d6;
   logic                               is_quick;
   logic [wctd_pkg::QDIG_W-1:0]        qd;
   logic [wctd_pkg::QPAIR_W-1:0]       qpair;
   logic                               tok_start;
   wctd_pkg::run_type                  run_kind;
   logic [wctd_pkg::CNT_W-1:0]         run_count;
   logic [wctd_pkg::LEN_W-1:0]         run_len;
   logic                               has_char;
   logic [wctd_pkg::BYTE_W-1:0]        chr;
   logic                               nz, big, cut;
   logic [PROD_W-1:0]                  prod;
   logic [wctd_pkg::RUN_W-1:0]         run_n;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   assign b        = (req_tdata == wctd_pkg::BYTE_ALT_ZERO) ? '0 : req_tdata;
   // (b - 63) mod 64
   assign d6       = b[wctd_pkg::DIGIT_W-1:0] + wctd_pkg::DIGIT_W'(1);
   assign is_quick = (b >= wctd_pkg::QUICK_LO) && (b <= wctd_pkg::QUICK_HI);
   assign qd       = wctd_pkg::QDIG_W'(b - wctd_pkg::QUICK_LO);
   assign qpair    = wctd_pkg::QPAIR_W'(qlow_ff)
                   + wctd_pkg::QPAIR_W'(qd) * wctd_pkg::QUICK_BASE;

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      count_in  = count_ff;
      qlow_in   = qlow_ff;
      tok_start = 1'b0;
      run_kind  = wctd_pkg::RUN_NONE;
      run_count = '0;
      run_len   = length_ff;
      has_char  = 1'b0;
      chr       = '0;

      unique case (phase_ff)
         wctd_pkg::PH_OFF_LO: begin
            offset_in = {offset_ff[wctd_pkg::OFF_W-1:wctd_pkg::DIGIT_W], d6};
            phase_in  = wctd_pkg::PH_LEN_HI;
         end
         wctd_pkg::PH_LEN_HI: begin
            length_in = {1'b0, d6, {wctd_pkg::DIGIT_W{1'b0}}};
            phase_in  = wctd_pkg::PH_LEN_LO;
         end
         wctd_pkg::PH_LEN_LO: begin
            length_in = length_ff + wctd_pkg::LEN_W'(d6) + wctd_pkg::LEN_W'(1);
            phase_in  = wctd_pkg::PH_CNT_FIRST;
         end
         wctd_pkg::PH_CNT_FIRST: begin
            if (is_quick) begin
               qlow_in  = qd;
               phase_in = wctd_pkg::PH_CNT_QUICK;
            end else begin
               count_in = wctd_pkg::CNT_W'(d6) << 18;
               phase_in = wctd_pkg::PH_CNT_D1;
            end
         end
         wctd_pkg::PH_CNT_QUICK: begin
            phase_in = wctd_pkg::PH_IDLE;
            run_kind = wctd_pkg::RUN_COPY;
            if (is_quick) begin
               run_count = wctd_pkg::CNT_W'(qpair);
            end else begin
               // low digit alone, then this byte starts a new token
               run_count = wctd_pkg::CNT_W'(qlow_ff);
               tok_start = 1'b1;
            end
         end
         wctd_pkg::PH_CNT_D1: begin
            count_in = count_ff | (wctd_pkg::CNT_W'(d6) << 12);
            phase_in = wctd_pkg::PH_CNT_D2;
         end
         wctd_pkg::PH_CNT_D2: begin
            count_in = count_ff | (wctd_pkg::CNT_W'(d6) << 6);
            phase_in = wctd_pkg::PH_CNT_D3;
         end
         wctd_pkg::PH_CNT_D3: begin
            run_count = count_ff | wctd_pkg::CNT_W'(d6);
            count_in  = run_count;
            run_kind  = wctd_pkg::RUN_COPY;
            phase_in  = wctd_pkg::PH_IDLE;
         end
         wctd_pkg::PH_NAKED_QUICK: begin
            phase_in = wctd_pkg::PH_IDLE;
            run_kind = wctd_pkg::RUN_DUPE;
            run_len  = wctd_pkg::LEN_W'(1);
            if (is_quick) begin
               run_count = wctd_pkg::CNT_W'(qpair);
            end else begin
               run_count = wctd_pkg::CNT_W'(qlow_ff);
               tok_start = 1'b1;
            end
         end
         default: begin
            tok_start = 1'b1;
         end
      endcase

      if (tok_start) begin
         phase_in = wctd_pkg::PH_IDLE;
         priority if ((b >= wctd_pkg::INSTR_LO) && (b <= wctd_pkg::INSTR_HI)) begin
            has_char = 1'b1;
            chr      = wctd_pkg::instr_char(3'(b - wctd_pkg::INSTR_LO));
         end else if ((b >= wctd_pkg::COPY_LO) && (b <= wctd_pkg::COPY_HI)) begin
            offset_in = {d6, {wctd_pkg::DIGIT_W{1'b0}}};
            phase_in  = wctd_pkg::PH_OFF_LO;
         end else if (is_quick) begin
            qlow_in  = qd;
            phase_in = wctd_pkg::PH_NAKED_QUICK;
         end else begin
            // end mark or filler byte: nothing
            phase_in = wctd_pkg::PH_IDLE;
         end
      end
   end

   // run length = count * length, capped; both factors nonzero so any high bit means cut
   assign nz   = (|run_count) && (|run_len);
   assign big  = (|run_count[wctd_pkg::CNT_W-1:wctd_pkg::RUN_W])
              || (|run_len[wctd_pkg::LEN_W-1:wctd_pkg::RUN_W]);
   assign prod = PROD_W'(run_count[wctd_pkg::RUN_W-1:0])
               * PROD_W'(run_len[wctd_pkg::RUN_W-1:0]);
   assign cut  = nz && (big || (prod > PROD_W'(MAX_RUN)));
   assign run_n = !nz ? '0 : (cut ? wctd_pkg::RUN_W'(MAX_RUN) : prod[wctd_pkg::RUN_W-1:0]);

   always_comb begin
      cmd.kind     = (run_n != '0) ? run_kind : wctd_pkg::RUN_NONE;
      cmd.run_n    = run_n;
      cmd.offset   = offset_ff;
      cmd.length   = run_len;
      cmd.cut      = cut;
      cmd.has_char = has_char;
      cmd.chr      = chr;
   end

   assign push = accept && ((run_n != '0) || has_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wctd_pkg::PH_IDLE;
         offset_ff <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         qlow_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         qlow_ff   <= qlow_in;
      end
   end

endmodule

>>> rtl/wctd_queue.sv
// Short command queue between the parser and the run engine.
module wctd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wctd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output wctd_pkg::cmd_type head_cmd
);

   localparam int QAW = $clog2(wctd_pkg::Q_DEPTH);

   wctd_pkg::cmd_type  entry_ff [wctd_pkg::Q_DEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       fill_ff, fill_in;

   assign full      = (fill_ff == (QAW+1)'(wctd_pkg::Q_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(wctd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(wctd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + (QAW+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QAW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/wctd_back.sv
// Run engine: executes commands against the history RAM and drives the result channel.
module wctd_back #(
   parameter int HISTORY_DEPTH = wctd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  wctd_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [wctd_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   wctd_pkg::back_state_type    state_ff, state_in;
   wctd_pkg::cmd_type           cmd_ff, cmd_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic                        full_ff, full_in;     // history wrapped once: all entries written
   logic [AW-1:0]               base_ff, base_in;
   logic [AW-1:0]               i_ff, i_in;
   logic [wctd_pkg::RUN_W-1:0]  k_ff, k_in;
   logic                        rd_ok_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [wctd_pkg::BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_cut_ff, rsp_cut_in;

   logic                        rd_en, wr_en;
   logic [AW-1:0]               rd_addr;
   logic [wctd_pkg::BYTE_W-1:0] wr_data, ram_q, hist_byte;
   logic                        out_free, load, run_done;
   logic [wctd_pkg::LEN_W-1:0]  i_plus;
   logic [AW-1:0]               i_next;

   wctd_ram #(
      .WIDTH (wctd_pkg::BYTE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // never-written entries read as zero
   assign hist_byte = rd_ok_ff ? ram_q : '0;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign run_done  = (k_ff == cmd_ff.run_n - wctd_pkg::RUN_W'(1));
   assign i_plus    = wctd_pkg::LEN_W'(i_ff) + wctd_pkg::LEN_W'(1);
   assign i_next    = (i_plus == cmd_ff.length) ? '0 : AW'(i_plus);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      wp_in       = wp_ff;
      full_in     = full_ff;
      base_in     = base_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      cmd_pop     = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = base_ff;
      wr_en       = 1'b0;
      wr_data     = '0;
      load        = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_cut_in  = rsp_cut_ff;

      unique case (state_ff)
         wctd_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               k_in    = '0;
               i_in    = '0;
               base_in = wp_ff - AW'(cmd.offset);
               unique case (cmd.kind)
                  wctd_pkg::RUN_COPY: begin
                     rd_addr  = base_in;
                     rd_en    = 1'b1;
                     state_in = wctd_pkg::BK_COPY;
                  end
                  wctd_pkg::RUN_DUPE: begin
                     rd_addr  = wp_ff - AW'(1);
                     rd_en    = 1'b1;
                     state_in = wctd_pkg::BK_DUPE;
                  end
                  default: begin
                     state_in = wctd_pkg::BK_CHAR;
                  end
               endcase
            end
         end
         wctd_pkg::BK_COPY: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = hist_byte;
               rsp_last_in = run_done && !cmd_ff.has_char;
               rsp_cut_in  = cmd_ff.cut;
               if (run_done) begin
                  state_in = cmd_ff.has_char ? wctd_pkg::BK_CHAR : wctd_pkg::BK_IDLE;
               end else begin
                  k_in    = k_ff + wctd_pkg::RUN_W'(1);
                  i_in    = i_next;
                  rd_addr = base_ff + i_next;
                  rd_en   = 1'b1;
               end
            end
         end
         wctd_pkg::BK_DUPE: begin
            // read data register holds the repeated byte for the whole run
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = hist_byte;
               rsp_last_in = run_done && !cmd_ff.has_char;
               rsp_cut_in  = cmd_ff.cut;
               wr_en       = 1'b1;
               wr_data     = hist_byte;
               wp_in       = wp_ff + AW'(1);
               full_in     = full_ff || (wp_ff == '1);
               if (run_done) begin
                  state_in = cmd_ff.has_char ? wctd_pkg::BK_CHAR : wctd_pkg::BK_IDLE;
               end else begin
                  k_in = k_ff + wctd_pkg::RUN_W'(1);
               end
            end
         end
         wctd_pkg::BK_CHAR: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = cmd_ff.chr;
               rsp_last_in = 1'b1;
               rsp_cut_in  = cmd_ff.cut;
               wr_en       = 1'b1;
               wr_data     = cmd_ff.chr;
               wp_in       = wp_ff + AW'(1);
               full_in     = full_ff || (wp_ff == '1);
               state_in    = wctd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = wctd_pkg::BK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wctd_pkg::BK_IDLE;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      base_ff     <= base_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_cut_ff  <= rsp_cut_in;
      if (rd_en) begin
         rd_ok_ff <= full_ff || (rd_addr < wp_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_cut_ff;

endmodule

>>> rtl/window_copy_token_decompressor.sv
// Top level: token parser, command queue and run engine with its history RAM.
// Throughput: the parser takes one request per cycle while the 2-entry queue has room;
// the run engine gives one result per cycle (history RAM read port) unless the result
// channel stalls, and it returns to idle between commands; a request gives 0 to
// MAX_RUN+1 results.
// Reset: synchronous; control and write pointer clear, no clearing pass:
// history entries not written since reset read as zero.
module window_copy_token_decompressor #(
   parameter int HISTORY_DEPTH = wctd_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_RUN       = wctd_pkg::MAX_RUN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last
   output logic       rsp_tuser    // [0] truncated
);

   wctd_pkg::cmd_type push_cmd, head_cmd;
   logic              push, q_full, q_not_empty, pop;

   wctd_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   wctd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   wctd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
